// ----- rtl/core/maf_pkg.sv -----
package maf_pkg;

   localparam int MAX_WINDOW   = 10;
   localparam int SAMPLE_WIDTH = 16;
   localparam int WINDOW_WIDTH = 4;

   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = WINDOW_WIDTH'(1);

endpackage

// ----- rtl/core/maf_ram.sv -----
module maf_ram #(
   parameter int WIDTH = maf_pkg::SAMPLE_WIDTH,
   parameter int DEPTH = maf_pkg::MAX_WINDOW
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/maf_div.sv -----
module maf_div #(
   parameter int DVD_W = maf_pkg::SAMPLE_WIDTH + 4,
   parameter int DVS_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/core/moving_average_filter.sv -----
// a request goes from ST_IDLE through the history reads (ST_READ) and the serial divide
// (ST_DIVIDE) before the mean is registered; req_ready is high only in ST_IDLE, so a new
// request waits for the previous mean; history ram gives one sample per cycle,
// then the serial divider takes one quotient bit per cycle; a stalled mean delays the next
// reset: synchronous, history reads as zero until written (fill count), window size 1
module moving_average_filter #(
   parameter int MAX_WINDOW   = maf_pkg::MAX_WINDOW,
   parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_mean,
   input  logic                                  csr_we,
   input  logic [maf_pkg::WINDOW_WIDTH-1:0]      csr_window_size
);

   localparam int WW     = maf_pkg::WINDOW_WIDTH;
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int ADDR_W = $clog2(MAX_WINDOW);
   localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
   localparam int CMP_W  = (CNT_W > WW) ? CNT_W : WW;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_WINDOW - 1);
   localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_WINDOW);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE
   } state_type;

   state_type                 state_ff, state_in;
   logic [WW-1:0]             window_ff;
   logic [ADDR_W-1:0]         wptr_ff, wptr_in;
   logic [ADDR_W-1:0]         rptr_ff, rptr_in;
   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic [CNT_W-1:0]          left_ff, left_in;
   logic [CNT_W-1:0]          age_ff, age_in;
   logic [CNT_W-1:0]          win_ff, win_in;
   logic                      pend_ff, pend_in;
   logic                      live_ff, live_in;
   logic                      neg_ff, neg_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]   rsp_mean_ff, rsp_mean_in;

   logic [CMP_W-1:0]          window_ext;
   logic [CNT_W-1:0]          win_eff;
   logic                      ram_we;
   logic                      ram_re;
   logic [SAMPLE_WIDTH-1:0]   ram_rd_data;
   logic                      div_start;
   logic                      div_done;
   logic [SUM_W-1:0]          div_dividend;
   logic [SUM_W-1:0]          div_quotient;
   logic [SUM_W-1:0]          signed_quotient;

   // clamp window to 1..MAX_WINDOW
   assign window_ext = CMP_W'(window_ff);
   always_comb begin
      priority if (window_ext == '0) begin
         win_eff = CNT_W'(1);
      end else if (window_ext > CMP_W'(MAX_WINDOW)) begin
         win_eff = MAX_CNT;
      end else begin
         win_eff = CNT_W'(window_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= maf_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         window_ff <= csr_window_size;
      end
   end

   assign div_dividend    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign signed_quotient = neg_ff ? SUM_W'(-div_quotient) : div_quotient;

   always_comb begin
      state_in     = state_ff;
      wptr_in      = wptr_ff;
      rptr_in      = rptr_ff;
      fill_in      = fill_ff;
      left_in      = left_ff;
      age_in       = age_ff;
      win_in       = win_ff;
      pend_in      = pend_ff;
      live_in      = live_ff;
      neg_in       = neg_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ram_we  = 1'b1;
               sum_in  = {{CNT_W{req_sample[SAMPLE_WIDTH-1]}}, req_sample};
               wptr_in = (wptr_ff == LAST_ADDR) ? '0 : wptr_ff + ADDR_W'(1);
               rptr_in = (wptr_ff == '0) ? LAST_ADDR : wptr_ff - ADDR_W'(1);
               fill_in = (fill_ff == MAX_CNT) ? fill_ff : fill_ff + CNT_W'(1);
               left_in = win_eff - CNT_W'(1);
               age_in  = CNT_W'(1);
               win_in  = win_eff;
               pend_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            pend_in = 1'b0;
            if (left_ff != '0) begin
               // older sample k is real only if k earlier requests exist
               ram_re  = 1'b1;
               pend_in = 1'b1;
               live_in = age_ff < fill_ff;
               age_in  = age_ff + CNT_W'(1);
               left_in = left_ff - CNT_W'(1);
               rptr_in = (rptr_ff == '0) ? LAST_ADDR : rptr_ff - ADDR_W'(1);
            end
            if (pend_ff && live_ff) begin
               sum_in = sum_ff + {{CNT_W{ram_rd_data[SAMPLE_WIDTH-1]}}, ram_rd_data};
            end
            if (left_ff == '0 && !pend_ff) begin
               div_start = 1'b1;
               neg_in    = sum_ff[SUM_W-1];
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = signed_quotient[SAMPLE_WIDTH-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rptr_ff     <= rptr_in;
      age_ff      <= age_in;
      win_ff      <= win_in;
      live_ff     <= live_in;
      neg_ff      <= neg_in;
      sum_ff      <= sum_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   maf_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wptr_ff),
      .wr_data (req_sample),
      .rd_en   (ram_re),
      .rd_addr (rptr_ff),
      .rd_data (ram_rd_data)
   );

   maf_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (win_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_mean  = rsp_mean_ff;

endmodule
